@@ rtl/cbpw_pkg.sv @@
`timescale 1ns / 1ps

package cbpw_pkg;

   // bitmap dimension limit and counter widths
   localparam int MAX_DIM = 4096;
   localparam int CNT_W   = 12;
   localparam int DIM_W   = 13;
   localparam int POS_W   = 18;

   // register indexes of the configuration port
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] REG_LINE_PITCH    = 3'd2;
   localparam logic [2:0] REG_BYTES_PER_PIX = 3'd3;
   localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd4;
   localparam logic [2:0] REG_CLIP_ENABLE   = 3'd5;
   localparam logic [2:0] REG_CLIP_WINDOW   = 3'd6;
   localparam logic [2:0] REG_BLIT_GEOMETRY = 3'd7;

   // pixel format codes
   localparam logic [1:0] FMT_UNKNOWN = 2'd0;
   localparam logic [1:0] FMT_RGB888  = 2'd1;
   localparam logic [1:0] FMT_BGR888  = 2'd2;
   localparam logic [1:0] FMT_RGB565  = 2'd3;

   // bytes per pixel codes that write
   localparam logic [2:0] BPP_2 = 3'd2;
   localparam logic [2:0] BPP_3 = 3'd3;
   localparam logic [2:0] BPP_4 = 3'd4;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_in_type;

   typedef struct packed {
      logic        write_enable;
      logic [25:0] byte_offset;
      logic [31:0] pixel_word;
      logic [2:0]  byte_count;
      logic        last_pixel;
   } pixel_out_type;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [14:0] line_pitch_bytes;
      logic [2:0]  bytes_per_pixel;
      logic [1:0]  pixel_format;
      logic        clip_enable;
      logic [63:0] clip_window;
      logic [63:0] blit_geometry;
   } cfg_type;

   // placed pixel between the walker and the output stage
   typedef struct packed {
      pixel_in_type            pixel;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    last;
      logic                    empty;
   } placed_type;

endpackage

@@ rtl/cbpw_walk.sv @@
`timescale 1ns / 1ps

module cbpw_walk import cbpw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         geo_write,
   input  logic         in_fire,
   input  pixel_in_type in_pixel,
   input  logic         out_ready,
   output logic         stage_valid,
   output placed_type   stage_data
);

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             stage_valid_ff, stage_valid_in;
   placed_type       stage_data_ff, stage_data_in;

   logic [15:0]      w_raw, h_raw;
   logic [DIM_W-1:0] w_sat, h_sat;
   logic [DIM_W-1:0] col_nx, row_nx;
   logic             empty, col_end, row_end;
   logic [15:0]      org_x, org_y;

   // saturated bitmap size and end-of-row / end-of-bitmap tests
   always_comb begin
      w_raw   = cfg.blit_geometry[47:32];
      h_raw   = cfg.blit_geometry[63:48];
      org_x   = cfg.blit_geometry[15:0];
      org_y   = cfg.blit_geometry[31:16];
      w_sat   = (w_raw > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM) : w_raw[DIM_W-1:0];
      h_sat   = (h_raw > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM) : h_raw[DIM_W-1:0];
      empty   = (w_sat == '0) || (h_sat == '0);
      col_nx  = {1'b0, col_ff} + DIM_W'(1);
      row_nx  = {1'b0, row_ff} + DIM_W'(1);
      col_end = col_nx >= w_sat;
      row_end = row_nx >= h_sat;
   end

   // counter advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (geo_write) begin
         col_in = '0;
         row_in = '0;
      end else if (in_fire) begin
         if (empty) begin
            col_in = '0;
            row_in = '0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_nx[CNT_W-1:0];
         end else begin
            col_in = col_nx[CNT_W-1:0];
         end
      end
   end

   // stage register: screen position of the pixel
   always_comb begin
      stage_data_in = stage_data_ff;
      if (in_fire) begin
         stage_data_in.pixel = in_pixel;
         stage_data_in.pos_x = $signed({{(POS_W-16){org_x[15]}}, org_x})
                             + $signed({{(POS_W-CNT_W){1'b0}}, col_ff});
         stage_data_in.pos_y = $signed({{(POS_W-16){org_y[15]}}, org_y})
                             + $signed({{(POS_W-CNT_W){1'b0}}, row_ff});
         stage_data_in.last  = empty || (col_end && row_end);
         stage_data_in.empty = empty;
      end
      if (in_fire) begin
         stage_valid_in = 1'b1;
      end else if (out_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_data_ff <= stage_data_in;
   end

   assign stage_valid = stage_valid_ff;
   assign stage_data  = stage_data_ff;

endmodule

@@ rtl/cbpw_emit.sv @@
`timescale 1ns / 1ps

module cbpw_emit import cbpw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          stage_valid,
   input  placed_type    stage_data,
   input  logic          rsp_stall,
   output logic          out_ready,
   output logic          rsp_valid,
   output pixel_out_type rsp_data
);

   logic          rsp_valid_ff, rsp_valid_in;
   pixel_out_type rsp_data_ff, rsp_data_in;

   logic signed [POS_W-1:0] x, y;
   logic signed [POS_W-1:0] clip_x1, clip_y1, clip_x2, clip_y2;
   logic signed [POS_W-1:0] scr_w, scr_h;
   logic        in_clip, on_screen, bpp_ok, ok;
   logic [27:0] row_bytes;
   logic [15:0] col_bytes;
   logic [31:0] packed_px, masked_px;

   // clip window and screen tests
   always_comb begin
      x         = stage_data.pos_x;
      y         = stage_data.pos_y;
      clip_x1   = $signed({2'b00, cfg.clip_window[15:0]});
      clip_y1   = $signed({2'b00, cfg.clip_window[31:16]});
      clip_x2   = $signed({2'b00, cfg.clip_window[47:32]});
      clip_y2   = $signed({2'b00, cfg.clip_window[63:48]});
      scr_w     = $signed({{(POS_W-13){1'b0}}, cfg.screen_width});
      scr_h     = $signed({{(POS_W-13){1'b0}}, cfg.screen_height});
      in_clip   = !cfg.clip_enable
                  || ((x >= clip_x1) && (x < clip_x2) && (y >= clip_y1) && (y < clip_y2));
      on_screen = !x[POS_W-1] && !y[POS_W-1] && (x < scr_w) && (y < scr_h);
      bpp_ok    = (cfg.bytes_per_pixel == BPP_2) || (cfg.bytes_per_pixel == BPP_3)
                  || (cfg.bytes_per_pixel == BPP_4);
      ok        = !stage_data.empty && (stage_data.pixel.alpha != 8'h00)
                  && in_clip && on_screen && bpp_ok;
   end

   // byte offset inside the buffer, wraps at 26 bits
   always_comb begin
      row_bytes = {15'b0, y[12:0]} * {13'b0, cfg.line_pitch_bytes};
      col_bytes = {3'b0, x[12:0]} * {13'b0, cfg.bytes_per_pixel};
   end

   // color packing and byte masking
   always_comb begin
      case (cfg.pixel_format)
         FMT_RGB888: packed_px = {8'h00, stage_data.pixel.red, stage_data.pixel.green,
                                  stage_data.pixel.blue};
         FMT_BGR888: packed_px = {8'h00, stage_data.pixel.blue, stage_data.pixel.green,
                                  stage_data.pixel.red};
         FMT_RGB565: packed_px = {16'h0000, stage_data.pixel.red[7:3],
                                  stage_data.pixel.green[7:2], stage_data.pixel.blue[7:3]};
         default:    packed_px = '0;
      endcase
      case (cfg.bytes_per_pixel)
         BPP_2:   masked_px = {16'h0000, packed_px[15:0]};
         BPP_3:   masked_px = {8'h00, packed_px[23:0]};
         default: masked_px = packed_px;
      endcase
   end

   // result register, loads whenever the output side is free
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in             = stage_valid;
         rsp_data_in.write_enable = ok;
         rsp_data_in.byte_offset  = ok ? 26'(row_bytes + {12'b0, col_bytes}) : '0;
         rsp_data_in.pixel_word   = ok ? masked_px : '0;
         rsp_data_in.byte_count   = ok ? cfg.bytes_per_pixel : '0;
         rsp_data_in.last_pixel   = stage_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/clipped_bitmap_pixel_writer_top.sv @@
`timescale 1ns / 1ps

// Bitmap pixel writer with clipping.
// The req channel takes one RGBA bitmap pixel per transfer, in row-major order.
// The rsp channel gives one result per pixel: write enable, byte offset in the
// frame buffer, the packed pixel word, the byte count and a last-pixel flag.
// The csr channel writes the eight setup registers (screen size, pitch, bytes
// per pixel, format, clip enable, clip window, blit geometry); it is always
// ready. Writing blit geometry restarts the column and row counters.
// A req transfer reaches its rsp through a register that holds the placed
// position and then one that holds the finished result. One pixel per cycle
// is sustained while rsp_stall is low; the per-pixel path is one 13x15 multiply
// and a 26-bit add. When rsp_stall is high the result holds and one more pixel
// may enter the position register; req_stall rises only when both are full.
// Reset loads the register defaults (640x480, pitch 2560, 4 bytes, RGB888,
// clipping off, empty bitmap), clears the counters and empties both stages.
// Users must make setup writes only while no pixel is in flight (not enforced).
module clipped_bitmap_pixel_writer_top import cbpw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  pixel_in_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output pixel_out_type rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       csr_fire, geo_write;
   logic       in_fire, out_ready, stage_valid;
   placed_type stage_data;

   // setup register decode
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign geo_write = csr_fire && (csr_index == REG_BLIT_GEOMETRY);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  cfg_in.screen_width     = csr_data[12:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height    = csr_data[12:0];
            REG_LINE_PITCH:    cfg_in.line_pitch_bytes = csr_data[14:0];
            REG_BYTES_PER_PIX: cfg_in.bytes_per_pixel  = csr_data[2:0];
            REG_PIXEL_FORMAT:  cfg_in.pixel_format     = csr_data[1:0];
            REG_CLIP_ENABLE:   cfg_in.clip_enable      = csr_data[0];
            REG_CLIP_WINDOW:   cfg_in.clip_window      = csr_data;
            REG_BLIT_GEOMETRY: cfg_in.blit_geometry    = csr_data;
            default:           cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width     <= 13'd640;
         cfg_ff.screen_height    <= 13'd480;
         cfg_ff.line_pitch_bytes <= 15'd2560;
         cfg_ff.bytes_per_pixel  <= BPP_4;
         cfg_ff.pixel_format     <= FMT_RGB888;
         cfg_ff.clip_enable      <= 1'b0;
         cfg_ff.clip_window      <= '0;
         cfg_ff.blit_geometry    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input transfer when the position stage can move on
   assign req_stall = stage_valid && !out_ready;
   assign in_fire   = req_valid && !req_stall;

   cbpw_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .geo_write   (geo_write),
      .in_fire     (in_fire),
      .in_pixel    (req_data),
      .out_ready   (out_ready),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   cbpw_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .rsp_stall   (rsp_stall),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

@@ rtl/cbpw_check.sv @@
`timescale 1ns / 1ps

module cbpw_check import cbpw_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input pixel_out_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a skipped pixel carries zero offset, word and count
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |->
         rsp_data.byte_offset == '0 && rsp_data.pixel_word == '0
         && rsp_data.byte_count == '0)
      else $error("skipped pixel with nonzero payload");

   // a written pixel stores two, three or four bytes
   a_write_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_enable |->
         rsp_data.byte_count == BPP_2 || rsp_data.byte_count == BPP_3
         || rsp_data.byte_count == BPP_4)
      else $error("written pixel with bad byte count");

   // a two-byte word has no bits above its byte count
   a_word_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_count == BPP_2 |-> rsp_data.pixel_word[31:16] == '0)
      else $error("pixel word wider than byte count");

endmodule

bind clipped_bitmap_pixel_writer_top cbpw_check u_cbpw_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ bench/clipped_bitmap_pixel_writer_checker.sv @@
`timescale 1ns / 1ps

module clipped_bitmap_pixel_writer_checker import cbpw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  pixel_in_type  req_data,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  pixel_out_type rsp_data,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data,
   output int            mismatch_count,
   output int            writes_pending,
   output int            results_checked,
   output int            pixels_stored,
   output int            bitmaps_ended
);

   // shadow copy of the setup registers
   logic [12:0] scr_w;
   logic [12:0] scr_h;
   logic [14:0] pitch;
   logic [2:0]  bpp;
   logic [1:0]  fmt;
   logic        clip_on;
   logic [63:0] clip_win;
   logic [63:0] geom;

   // bitmap walk position
   int col_pos;
   int row_pos;

   pixel_out_type expected_writes[$];

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [31:0] color_word(pixel_in_type px);
      case (fmt)
         FMT_RGB888: return {8'h00, px.red, px.green, px.blue};
         FMT_BGR888: return {8'h00, px.blue, px.green, px.red};
         FMT_RGB565: return {16'h0000, px.red[7:3], px.green[7:2], px.blue[7:3]};
         default:    return 32'h0000_0000;
      endcase
   endfunction

   // place one pixel, decide whether it lands, and step the walk
   function automatic pixel_out_type compute_write(pixel_in_type px);
      pixel_out_type res;
      int org_x, org_y, bm_w, bm_h, pos_x, pos_y;
      logic lands;
      logic [31:0] word;
      longint lin;
      res = '0;
      org_x = $signed(geom[15:0]);
      org_y = $signed(geom[31:16]);
      bm_w = int'(geom[47:32]);
      bm_h = int'(geom[63:48]);
      if (bm_w > MAX_DIM) bm_w = MAX_DIM;
      if (bm_h > MAX_DIM) bm_h = MAX_DIM;

      // empty bitmap swallows every pixel
      if (bm_w == 0 || bm_h == 0) begin
         col_pos = 0;
         row_pos = 0;
         res.last_pixel = 1'b1;
         return res;
      end

      pos_x = org_x + col_pos;
      pos_y = org_y + row_pos;
      lands = (px.alpha != 8'h00);
      if (clip_on && (pos_x < int'(clip_win[15:0]) || pos_x >= int'(clip_win[47:32]) ||
                      pos_y < int'(clip_win[31:16]) || pos_y >= int'(clip_win[63:48])))
         lands = 1'b0;
      if (pos_x < 0 || pos_x >= int'(scr_w) || pos_y < 0 || pos_y >= int'(scr_h))
         lands = 1'b0;
      if (bpp < BPP_2 || bpp > BPP_4)
         lands = 1'b0;

      if (lands) begin
         word = color_word(px);
         case (bpp)
            BPP_2:   word = word & 32'h0000_FFFF;
            BPP_3:   word = word & 32'h00FF_FFFF;
            default: ;
         endcase
         lin = longint'(pos_y) * longint'(pitch) + longint'(pos_x) * longint'(bpp);
         res.write_enable = 1'b1;
         res.byte_count   = bpp;
         res.byte_offset  = lin[25:0];
         res.pixel_word   = word;
      end

      // row-major walk
      if (col_pos + 1 >= bm_w) begin
         col_pos = 0;
         if (row_pos + 1 >= bm_h) begin
            row_pos = 0;
            res.last_pixel = 1'b1;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col_pos + 1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_out_type want;
      if (reset) begin
         scr_w = 13'd640;
         scr_h = 13'd480;
         pitch = 15'd2560;
         bpp = BPP_4;
         fmt = FMT_RGB888;
         clip_on = 1'b0;
         clip_win = '0;
         geom = '0;
         col_pos = 0;
         row_pos = 0;
         expected_writes.delete();
         mismatch_count = 0;
         results_checked = 0;
         pixels_stored = 0;
         bitmaps_ended = 0;
      end else begin
         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SCREEN_WIDTH:  scr_w = csr_data[12:0];
               REG_SCREEN_HEIGHT: scr_h = csr_data[12:0];
               REG_LINE_PITCH:    pitch = csr_data[14:0];
               REG_BYTES_PER_PIX: bpp = csr_data[2:0];
               REG_PIXEL_FORMAT:  fmt = csr_data[1:0];
               REG_CLIP_ENABLE:   clip_on = csr_data[0];
               REG_CLIP_WINDOW:   clip_win = csr_data;
               REG_BLIT_GEOMETRY: begin
                  geom = csr_data;
                  col_pos = 0;
                  row_pos = 0;
               end
               default: ;
            endcase
         end

         // result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_writes.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_data, 0);
            end else begin
               want = expected_writes.pop_front();
               if (rsp_data.write_enable !== want.write_enable)
                  report_mismatch("write_enable", rsp_data.write_enable, want.write_enable);
               if (rsp_data.byte_offset !== want.byte_offset)
                  report_mismatch("byte_offset", rsp_data.byte_offset, want.byte_offset);
               if (rsp_data.pixel_word !== want.pixel_word)
                  report_mismatch("pixel_word", rsp_data.pixel_word, want.pixel_word);
               if (rsp_data.byte_count !== want.byte_count)
                  report_mismatch("byte_count", rsp_data.byte_count, want.byte_count);
               if (rsp_data.last_pixel !== want.last_pixel)
                  report_mismatch("last_pixel", rsp_data.last_pixel, want.last_pixel);
               if (want.write_enable) pixels_stored++;
               if (want.last_pixel) bitmaps_ended++;
            end
         end

         // pixel transfer
         if (req_valid && !req_stall)
            expected_writes.push_back(compute_write(req_data));
      end
      writes_pending = expected_writes.size();
   end

endmodule

@@ bench/clipped_bitmap_pixel_writer_top_test.sv @@
`timescale 1ns / 1ps

module clipped_bitmap_pixel_writer_top_test;
   import cbpw_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 650;
   localparam int LONG_HOLD    = 60;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   pixel_in_type  req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   pixel_out_type rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [2:0]    csr_index;
   logic [63:0]   csr_data;

   int  mismatch_count;
   int  writes_pending;
   int  results_checked;
   int  pixels_stored;
   int  bitmaps_ended;
   int  cycle_count = 0;
   int  setups_run = 0;
   bit  gapless;
   bit  hold_trigger;
   bit  hold_served;

   clipped_bitmap_pixel_writer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   clipped_bitmap_pixel_writer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .writes_pending  (writes_pending),
      .results_checked (results_checked),
      .pixels_stored   (pixels_stored),
      .bitmaps_ended   (bitmaps_ended)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, writes_pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side stall pattern, with one long hold on request
   initial begin : rsp_side
      int pick;
      int run;
      rsp_stall = 1'b0;
      hold_served = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               rsp_stall <= 1'b0;
               run = $urandom_range(1, 20);
            end else if (pick < 95) begin
               rsp_stall <= 1'b1;
               run = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               run = $urandom_range(10, 40);
            end
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   function automatic logic [63:0] geom_word(int ox, int oy, int w, int h);
      return {16'(h), 16'(w), 16'(oy), 16'(ox)};
   endfunction

   function automatic logic [63:0] window_word(int x1, int y1, int x2, int y2);
      return {16'(y2), 16'(x2), 16'(y1), 16'(x1)};
   endfunction

   // random bits above the register width, which the block must drop
   function automatic logic [63:0] with_junk(int val, int width);
      return ({$urandom, $urandom} << width) | 64'(val);
   endfunction

   function automatic pixel_in_type rand_pixel();
      pixel_in_type px;
      px = $urandom;
      if ($urandom_range(0, 6) == 0) px.alpha = 8'h00;
      return px;
   endfunction

   // origin that often straddles a screen edge
   function automatic int place_coord(int extent, int span);
      case ($urandom_range(0, 9))
         0:       return int'($urandom_range(0, 65535)) - 32768;
         1, 2, 3: return -int'($urandom_range(0, span));
         4, 5, 6: return extent - int'($urandom_range(0, span));
         default: return int'($urandom_range(0, extent));
      endcase
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(pixel_in_type px);
      int gap;
      int pick;
      gap = 0;
      if (!gapless) begin
         pick = $urandom_range(0, 99);
         if (pick >= 95) gap = $urandom_range(8, 30);
         else if (pick >= 65) gap = $urandom_range(1, 3);
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and let every outstanding result come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(negedge clock); while (writes_pending != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic random_setup(output int bm_w, output int bm_h);
      int sw, sh, pitch_v, bpp_v, ox, oy, span_x, span_y, x1, y1, x2, y2, pick;
      logic [63:0] win;
      bpp_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         sw = 8191;
         sh = 8191;
         pitch_v = 32767;
         bpp_v = BPP_4;
      end else if (pick == 1) begin
         sw = 1;
         sh = 1;
         pitch_v = 0;
      end else if (pick == 2) begin
         sw = $urandom_range(0, 8191);
         sh = $urandom_range(0, 8191);
         pitch_v = $urandom_range(0, 32767);
      end else begin
         sw = $urandom_range(1, 40);
         sh = $urandom_range(1, 30);
         pitch_v = sw * bpp_v + $urandom_range(0, 16);
      end

      bm_w = $urandom_range(1, 12);
      bm_h = $urandom_range(1, 8);
      case ($urandom_range(0, 19))
         0:       bm_w = 0;
         1:       bm_h = 0;
         2:       bm_w = $urandom_range(4097, 65535);
         3:       bm_h = $urandom_range(4097, 65535);
         default: ;
      endcase
      span_x = (bm_w > 16) ? 16 : bm_w;
      span_y = (bm_h > 16) ? 16 : bm_h;
      ox = place_coord(sw, span_x);
      oy = place_coord(sh, span_y);

      // clip window mostly overlapping the bitmap
      x1 = ox + int'($urandom_range(0, span_x));
      y1 = oy + int'($urandom_range(0, span_y));
      if (x1 < 0) x1 = 0;
      if (y1 < 0) y1 = 0;
      x2 = x1 + int'($urandom_range(0, span_x + 1));
      y2 = y1 + int'($urandom_range(0, span_y + 1));
      win = window_word(x1, y1, x2, y2);
      if ($urandom_range(0, 9) == 0) win = {$urandom, $urandom};

      write_reg(REG_SCREEN_WIDTH, with_junk(sw, 13));
      write_reg(REG_SCREEN_HEIGHT, with_junk(sh, 13));
      write_reg(REG_LINE_PITCH, with_junk(pitch_v, 15));
      write_reg(REG_BYTES_PER_PIX, with_junk(bpp_v, 3));
      write_reg(REG_PIXEL_FORMAT, with_junk($urandom_range(0, 3), 2));
      write_reg(REG_CLIP_ENABLE, with_junk($urandom_range(0, 1), 1));
      write_reg(REG_CLIP_WINDOW, win);
      write_reg(REG_BLIT_GEOMETRY, geom_word(ox, oy, bm_w, bm_h));
      setups_run++;
   endtask

   initial begin : stimulus
      int bm_w, bm_h, n, sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_SCREEN_WIDTH;
      csr_data = '0;
      gapless = 1'b0;
      hold_trigger = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setup has an empty bitmap: every pixel ends it
      send_pixel(rand_pixel());
      send_pixel(rand_pixel());
      wait_idle();

      // defaults written back, bitmap hanging off the left edge
      write_reg(REG_SCREEN_WIDTH, 64'd640);
      write_reg(REG_SCREEN_HEIGHT, 64'd480);
      write_reg(REG_LINE_PITCH, 64'd2560);
      write_reg(REG_BYTES_PER_PIX, 64'(BPP_4));
      write_reg(REG_PIXEL_FORMAT, 64'(FMT_RGB888));
      write_reg(REG_CLIP_ENABLE, 64'd0);
      write_reg(REG_CLIP_WINDOW, window_word(0, 0, 16'hFFFF, 16'hFFFF));
      write_reg(REG_BLIT_GEOMETRY, geom_word(-1, 0, 3, 2));
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_pixel({8'h00, 8'h00, 8'h00, 8'h00});
      send_pixel({8'hFF, 8'h00, 8'h80, 8'h01});
      send_pixel({8'h00, 8'hFF, 8'h7F, 8'hFF});
      send_pixel({8'h12, 8'h34, 8'h56, 8'h80});
      send_pixel({8'hA5, 8'h5A, 8'hC3, 8'h00});
      wait_idle();

      // three byte BGR with a one pixel clip window
      write_reg(REG_PIXEL_FORMAT, 64'(FMT_BGR888));
      write_reg(REG_BYTES_PER_PIX, 64'(BPP_3));
      write_reg(REG_CLIP_ENABLE, 64'd1);
      write_reg(REG_CLIP_WINDOW, window_word(1, 0, 2, 1));
      write_reg(REG_BLIT_GEOMETRY, geom_word(0, 0, 3, 1));
      repeat (3) send_pixel({8'h11, 8'h22, 8'h33, 8'hFF});
      wait_idle();

      // two byte 565
      write_reg(REG_PIXEL_FORMAT, 64'(FMT_RGB565));
      write_reg(REG_BYTES_PER_PIX, 64'(BPP_2));
      write_reg(REG_CLIP_ENABLE, 64'd0);
      write_reg(REG_BLIT_GEOMETRY, geom_word(5, 5, 2, 1));
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_pixel({8'h08, 8'h04, 8'h08, 8'hFF});
      wait_idle();

      // unknown format packs zero
      write_reg(REG_PIXEL_FORMAT, 64'(FMT_UNKNOWN));
      write_reg(REG_BYTES_PER_PIX, 64'(BPP_4));
      write_reg(REG_BLIT_GEOMETRY, geom_word(0, 0, 1, 1));
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
      wait_idle();

      // one byte per pixel writes nothing
      write_reg(REG_PIXEL_FORMAT, 64'(FMT_RGB888));
      write_reg(REG_BYTES_PER_PIX, 64'd1);
      write_reg(REG_BLIT_GEOMETRY, geom_word(0, 0, 1, 1));
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
      wait_idle();

      // oversize bitmap saturates
      write_reg(REG_BYTES_PER_PIX, 64'(BPP_4));
      write_reg(REG_BLIT_GEOMETRY, geom_word(0, 0, 16'hFFFF, 16'hFFFF));
      send_pixel({8'h80, 8'h40, 8'h20, 8'h10});
      send_pixel({8'h01, 8'h02, 8'h04, 8'h08});
      wait_idle();

      // geometry rewritten mid-bitmap restarts the walk
      write_reg(REG_BLIT_GEOMETRY, geom_word(0, 0, 4, 4));
      send_pixel(rand_pixel());
      send_pixel(rand_pixel());
      wait_idle();
      write_reg(REG_BLIT_GEOMETRY, geom_word(0, 0, 2, 1));
      send_pixel({8'h5A, 8'hA5, 8'h3C, 8'hC3});
      send_pixel({8'hC3, 8'h3C, 8'hA5, 8'h5A});
      wait_idle();

      // largest screen and pitch, offset wraps
      write_reg(REG_SCREEN_WIDTH, 64'd8191);
      write_reg(REG_SCREEN_HEIGHT, 64'd8191);
      write_reg(REG_LINE_PITCH, 64'd32767);
      write_reg(REG_BLIT_GEOMETRY, geom_word(8000, 8100, 1, 1));
      send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
      wait_idle();
      setups_run += 9;

      // random setups, mostly whole bitmaps
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         random_setup(bm_w, bm_h);
         if (bm_w == 0 || bm_h == 0)
            n = $urandom_range(1, 4);
         else if (bm_w > MAX_DIM || bm_h > MAX_DIM)
            n = $urandom_range(1, 20);
         else if ($urandom_range(0, 6) == 0)
            n = $urandom_range(1, 2 * bm_w * bm_h);
         else
            n = bm_w * bm_h * $urandom_range(1, 3);
         // keep the total near the planned item count
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         gapless = ($urandom_range(0, 3) == 0);
         // first setup: back-to-back pixels against a long result hold
         if (!hold_trigger) begin
            if (n < 40) n = 40;
            gapless = 1'b1;
            hold_trigger <= 1'b1;
         end
         repeat (n) send_pixel(rand_pixel());
         sent += n;
         wait_idle();
      end

      $display("%0d pixels checked over %0d setups: %0d stored, %0d bitmap ends",
               results_checked, setups_run, pixels_stored, bitmaps_ended);
      $display("covered all formats and byte widths, clipping, empty and oversize bitmaps");
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ clipped_bitmap_pixel_writer_top.f @@
rtl/cbpw_pkg.sv
rtl/cbpw_walk.sv
rtl/cbpw_emit.sv
rtl/clipped_bitmap_pixel_writer_top.sv
rtl/cbpw_check.sv
bench/clipped_bitmap_pixel_writer_checker.sv
bench/clipped_bitmap_pixel_writer_top_test.sv
